FILE: rtl/core/mbhp_pkg.sv
`default_nettype none

package mbhp_pkg;

   // Field and datapath widths
   localparam int CHAN_W    = 3;
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 24;
   localparam int PROD_W    = COEF_W + SAMPLE_W;
   localparam int STATE_W   = 40;
   localparam int SUM_W     = STATE_W + 2;
   localparam int FRAC_BITS = 22;

   // APB-style register port
   localparam int DATA_W = 32;
   localparam int ADDR_W = 4;

   localparam int DEFAULT_CHANNELS = 8;

   // b0 resets to 1.0 in Q2.22
   localparam logic signed [COEF_W-1:0] COEF_B0_RESET = COEF_W'(24'h40_0000);

   // Rounding offset, half an output LSB
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << (FRAC_BITS - 1));

   // Output sample limits at accumulator width
   localparam logic signed [SUM_W-1:0] SUM_Y_MAX = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] SUM_Y_MIN = SUM_W'(-32768);

   // Delay state limits at accumulator width
   localparam logic signed [SUM_W-1:0] SUM_STATE_MAX =
      {{(SUM_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_STATE_MIN =
      {{(SUM_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};

   // Register indexes
   typedef enum logic [1:0] {
      REG_COEF_B0 = 2'd0,
      REG_COEF_B1 = 2'd1,
      REG_COEF_A1 = 2'd2,
      REG_COEF_A2 = 2'd3
   } reg_idx_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_B0X,
      ST_ROUND,
      ST_ADD_D2,
      ST_SUB_A1Y,
      ST_SUB_A2Y,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/multichannel_biquad_highpass_top.sv
// Multichannel biquad high-pass filter (direct form II transposed).
// Input channel req_*: one item is a channel number and a 16-bit sample;
// it is taken when req_valid is high and req_stall is low. Result channel
// rsp_*: channel echo, rounded and saturated sample, and a clip flag; the
// receiver holds it off with rsp_stall, and the result then stays put.
// Coefficients b0 (also b2), b1, a1, a2 are signed Q2.22 registers on the
// APB-style port at byte addresses 0, 4, 8, 12; pready is always high.
// One 24x16 multiplier and one 42-bit adder are shared under a small
// sequencer, one product and one sum per cycle. A valid channel steps
// through MUL_B0X, ROUND, ADD_D2, SUB_A1Y and SUB_A2Y to OUT, where its
// result shows; a channel beyond CHANNELS passes its sample straight to OUT.
// req_stall is high from acceptance until the result has been taken.
// Reset clears every channel's delay states, loads b0 = 1.0 and the other
// coefficients with zero, and empties the result register.
`default_nettype none

module multichannel_biquad_highpass_top #(
   parameter int CHANNELS = mbhp_pkg::DEFAULT_CHANNELS
) (
   input  wire                                       clock,
   input  wire                                       reset,
   // input samples
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  wire        [mbhp_pkg::CHAN_W-1:0]         req_chan,
   input  wire signed [mbhp_pkg::SAMPLE_W-1:0]       req_sample_in,
   // filtered samples
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output logic       [mbhp_pkg::CHAN_W-1:0]         rsp_chan_out,
   output logic signed [mbhp_pkg::SAMPLE_W-1:0]      rsp_sample_out,
   output logic                                      rsp_clipped,
   // coefficient registers
   input  wire                                       psel,
   input  wire                                       penable,
   input  wire                                       pwrite,
   input  wire        [mbhp_pkg::ADDR_W-1:0]         paddr,
   input  wire        [mbhp_pkg::DATA_W-1:0]         pwdata,
   output logic       [mbhp_pkg::DATA_W-1:0]         prdata,
   output logic                                      pready
);

   // Only channels reachable through the channel field hold state
   localparam int DEPTH = (CHANNELS < (1 << mbhp_pkg::CHAN_W)) ?
                          CHANNELS : (1 << mbhp_pkg::CHAN_W);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   mbhp_pkg::state_type state_ff, state_in;

   logic signed [mbhp_pkg::COEF_W-1:0]   coef_b0_ff, coef_b1_ff, coef_a1_ff, coef_a2_ff;
   logic        [mbhp_pkg::CHAN_W-1:0]   chan_ff;
   logic signed [mbhp_pkg::SAMPLE_W-1:0] x_ff;
   logic signed [mbhp_pkg::SAMPLE_W-1:0] y_ff;
   logic                                 clip_ff;
   logic signed [mbhp_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [mbhp_pkg::STATE_W-1:0]  bx_ff;
   logic signed [mbhp_pkg::SUM_W-1:0]    acc_ff;
   logic signed [mbhp_pkg::STATE_W-1:0]  d1n_ff;
   logic signed [mbhp_pkg::STATE_W-1:0]  delay_one_ff [DEPTH];
   logic signed [mbhp_pkg::STATE_W-1:0]  delay_two_ff [DEPTH];

   logic [IDX_W-1:0] idx;
   logic             chan_ok;
   logic             cfg_wr;

   // shared unit operands
   logic signed [mbhp_pkg::COEF_W-1:0]   mul_a;
   logic signed [mbhp_pkg::SAMPLE_W-1:0] mul_b;
   logic signed [mbhp_pkg::SUM_W-1:0]    add_a, add_b, add_sum;
   logic                                 add_sub;

   // rounding and saturation
   logic signed [mbhp_pkg::SUM_W-1:0]    rnd_sum, y_wide;
   logic signed [mbhp_pkg::SAMPLE_W-1:0] y_sat;
   logic                                 y_clip;
   logic signed [mbhp_pkg::STATE_W-1:0]  state_sat;

   assign idx     = chan_ff[IDX_W-1:0];
   assign chan_ok = int'(req_chan) < CHANNELS;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign pready  = 1'b1;

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= mbhp_pkg::COEF_B0_RESET;
         coef_b1_ff <= '0;
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
      end else if (cfg_wr) begin
         unique case (mbhp_pkg::reg_idx_type'(paddr[3:2]))
            mbhp_pkg::REG_COEF_B0: coef_b0_ff <= pwdata[mbhp_pkg::COEF_W-1:0];
            mbhp_pkg::REG_COEF_B1: coef_b1_ff <= pwdata[mbhp_pkg::COEF_W-1:0];
            mbhp_pkg::REG_COEF_A1: coef_a1_ff <= pwdata[mbhp_pkg::COEF_W-1:0];
            mbhp_pkg::REG_COEF_A2: coef_a2_ff <= pwdata[mbhp_pkg::COEF_W-1:0];
         endcase
      end
   end

   // Register readback, sign-extended
   always_comb begin
      unique case (mbhp_pkg::reg_idx_type'(paddr[3:2]))
         mbhp_pkg::REG_COEF_B0: prdata = mbhp_pkg::DATA_W'(coef_b0_ff);
         mbhp_pkg::REG_COEF_B1: prdata = mbhp_pkg::DATA_W'(coef_b1_ff);
         mbhp_pkg::REG_COEF_A1: prdata = mbhp_pkg::DATA_W'(coef_a1_ff);
         mbhp_pkg::REG_COEF_A2: prdata = mbhp_pkg::DATA_W'(coef_a2_ff);
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbhp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = chan_ok ? mbhp_pkg::ST_MUL_B0X : mbhp_pkg::ST_OUT;
            end
         end
         mbhp_pkg::ST_MUL_B0X: state_in = mbhp_pkg::ST_ROUND;
         mbhp_pkg::ST_ROUND:   state_in = mbhp_pkg::ST_ADD_D2;
         mbhp_pkg::ST_ADD_D2:  state_in = mbhp_pkg::ST_SUB_A1Y;
         mbhp_pkg::ST_SUB_A1Y: state_in = mbhp_pkg::ST_SUB_A2Y;
         mbhp_pkg::ST_SUB_A2Y: state_in = mbhp_pkg::ST_OUT;
         mbhp_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               state_in = mbhp_pkg::ST_IDLE;
            end
         end
         default: state_in = mbhp_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and operand selection
   always_comb begin
      req_stall = (state_ff != mbhp_pkg::ST_IDLE);
      rsp_valid = (state_ff == mbhp_pkg::ST_OUT);
      mul_a     = coef_b0_ff;
      mul_b     = x_ff;
      add_a     = mbhp_pkg::SUM_W'(prod_ff);
      add_b     = '0;
      add_sub   = 1'b0;
      unique case (state_ff)
         mbhp_pkg::ST_ROUND: begin
            // y from b0*x + d1; start b1*x
            mul_a = coef_b1_ff;
            add_b = mbhp_pkg::SUM_W'(delay_one_ff[idx]);
         end
         mbhp_pkg::ST_ADD_D2: begin
            // b1*x + d2; start a1*y
            mul_a = coef_a1_ff;
            mul_b = y_ff;
            add_b = mbhp_pkg::SUM_W'(delay_two_ff[idx]);
         end
         mbhp_pkg::ST_SUB_A1Y: begin
            // new d1; start a2*y
            mul_a   = coef_a2_ff;
            mul_b   = y_ff;
            add_a   = acc_ff;
            add_b   = mbhp_pkg::SUM_W'(prod_ff);
            add_sub = 1'b1;
         end
         mbhp_pkg::ST_SUB_A2Y: begin
            // new d2 from b0*x - a2*y
            add_a   = mbhp_pkg::SUM_W'(bx_ff);
            add_b   = mbhp_pkg::SUM_W'(prod_ff);
            add_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Shared multiplier and adder
   assign prod_in = mul_a * mul_b;
   assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

   // Round half up to sample units and saturate
   assign rnd_sum = add_sum + mbhp_pkg::ROUND_HALF;
   assign y_wide  = rnd_sum >>> mbhp_pkg::FRAC_BITS;
   always_comb begin
      y_clip = 1'b1;
      if (y_wide > mbhp_pkg::SUM_Y_MAX) begin
         y_sat = mbhp_pkg::SUM_Y_MAX[mbhp_pkg::SAMPLE_W-1:0];
      end else if (y_wide < mbhp_pkg::SUM_Y_MIN) begin
         y_sat = mbhp_pkg::SUM_Y_MIN[mbhp_pkg::SAMPLE_W-1:0];
      end else begin
         y_sat  = y_wide[mbhp_pkg::SAMPLE_W-1:0];
         y_clip = 1'b0;
      end
   end

   // Delay state saturation
   always_comb begin
      if (add_sum > mbhp_pkg::SUM_STATE_MAX) begin
         state_sat = mbhp_pkg::SUM_STATE_MAX[mbhp_pkg::STATE_W-1:0];
      end else if (add_sum < mbhp_pkg::SUM_STATE_MIN) begin
         state_sat = mbhp_pkg::SUM_STATE_MIN[mbhp_pkg::STATE_W-1:0];
      end else begin
         state_sat = add_sum[mbhp_pkg::STATE_W-1:0];
      end
   end

   // Control state and per-channel delay states
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbhp_pkg::ST_IDLE;
         for (int i = 0; i < DEPTH; i++) begin
            delay_one_ff[i] <= '0;
            delay_two_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == mbhp_pkg::ST_SUB_A2Y) begin
            delay_one_ff[idx] <= d1n_ff;
            delay_two_ff[idx] <= state_sat;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (state_ff == mbhp_pkg::ST_IDLE && req_valid) begin
         chan_ff <= req_chan;
         x_ff    <= req_sample_in;
         // out-of-range channel passes the sample through
         y_ff    <= req_sample_in;
         clip_ff <= 1'b0;
      end
      if (state_ff == mbhp_pkg::ST_ROUND) begin
         y_ff    <= y_sat;
         clip_ff <= y_clip;
         bx_ff   <= prod_ff;
      end
      if (state_ff == mbhp_pkg::ST_ADD_D2) begin
         acc_ff <= add_sum;
      end
      if (state_ff == mbhp_pkg::ST_SUB_A1Y) begin
         d1n_ff <= state_sat;
      end
   end

   assign rsp_chan_out   = chan_ff;
   assign rsp_sample_out = y_ff;
   assign rsp_clipped    = clip_ff;

endmodule

`default_nettype wire

FILE: rtl/core/mbhp_checker.sv
`default_nettype none

module mbhp_checker (
   input wire                                   clock,
   input wire                                   reset,
   input wire                                   req_valid,
   input wire                                   req_stall,
   input wire                                   rsp_valid,
   input wire                                   rsp_stall,
   input wire        [mbhp_pkg::CHAN_W-1:0]     rsp_chan_out,
   input wire signed [mbhp_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input wire                                   rsp_clipped
);

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A waiting result keeps the input side closed
   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result waits");

   // An item is taken only with no result outstanding
   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !rsp_valid)
      else $error("item taken while a result waits");

   // The clip flag only comes with a full-scale sample
   a_clip_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_sample_out == 16'sh7FFF || rsp_sample_out == 16'sh8000))
      else $error("clip flag on a sample below full scale");

   // A stalled result holds
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_sample_out) && $stable(rsp_chan_out)
          && $stable(rsp_clipped)))
      else $error("stalled result changed");

endmodule

bind multichannel_biquad_highpass_top mbhp_checker u_mbhp_checker (.*);

`default_nettype wire
